FILE: sv/u8d_pkg.sv
package u8d_pkg;

  // Class of a byte as seen when no sequence is open.
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } byte_kind_t;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    byte_kind_t  kind;
    logic [7:0]  data;
  } u8d_item_t;

  localparam int unsigned CP_W       = 21;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

endpackage

FILE: sv/u8d_front.sv
module u8d_front
  import u8d_pkg::*;
(
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       push,
  output u8d_item_t  item
);

  // Take a byte whenever the queue has room and reset is low.
  assign in_ready = !q_full && !rst;
  assign push     = in_valid && in_ready;

  // Classify the byte by its run of leading one bits.
  always_comb begin
    item.data = in_byte;
    case (in_byte) inside
      [8'h00:8'h7F]: item.kind = KIND_ASCII;
      [8'hC0:8'hDF]: item.kind = KIND_LEAD2;
      [8'hE0:8'hEF]: item.kind = KIND_LEAD3;
      [8'hF0:8'hF7]: item.kind = KIND_LEAD4;
      default:       item.kind = KIND_BAD;
    endcase
  end

endmodule

FILE: sv/u8d_queue.sv
module u8d_queue
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  u8d_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output u8d_item_t q_item
);

  u8d_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: sv/u8d_back.sv
module u8d_back
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  u8d_item_t       q_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point,
  output logic            bad_lead
);

  logic [1:0]      bytes_left;
  logic [CP_W-1:0] accumulator;
  logic [1:0]      bytes_left_next;
  logic [CP_W-1:0] accumulator_next;
  logic            emit;
  logic [CP_W-1:0] cp_next;
  logic            bad_next;

  // Take the next byte when the output register is free or being drained.
  assign pop = q_valid && (!out_valid || out_ready);

  // Sequence state update and result for the byte at the queue head.
  always_comb begin
    bytes_left_next  = bytes_left;
    accumulator_next = accumulator;
    emit             = 1'b0;
    cp_next          = CP_W'(q_item.data);
    bad_next         = 1'b0;
    if (bytes_left != 2'd0) begin
      accumulator_next = {accumulator[CP_W-7:0], q_item.data[5:0]};
      bytes_left_next  = bytes_left - 2'd1;
      emit             = (bytes_left == 2'd1);
      cp_next          = accumulator_next;
    end else begin
      case (q_item.kind)
        KIND_ASCII: begin
          emit = 1'b1;
        end
        KIND_LEAD2: begin
          accumulator_next = CP_W'(q_item.data[4:0]);
          bytes_left_next  = 2'd1;
        end
        KIND_LEAD3: begin
          accumulator_next = CP_W'(q_item.data[3:0]);
          bytes_left_next  = 2'd2;
        end
        KIND_LEAD4: begin
          accumulator_next = CP_W'(q_item.data[2:0]);
          bytes_left_next  = 2'd3;
        end
        default: begin
          emit     = 1'b1;
          bad_next = 1'b1;
        end
      endcase
    end
  end

  // Sequence state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= '0;
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else if (pop) begin
      bytes_left  <= bytes_left_next;
      accumulator <= accumulator_next;
      out_valid   <= emit;
    end else if (out_ready) begin
      out_valid   <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      code_point <= cp_next;
      bad_lead   <= bad_next;
    end
  end

endmodule

FILE: sv/utf8_stream_decoder_top.sv
// UTF-8 stream decoder.
// Input channel: one byte of a UTF-8 stream per request on in_byte, with
// in_valid / in_ready. Output channel: one decoded code point per request on
// code_point, with bad_lead set for a stray continuation byte or a lead byte
// of 0xF8 to 0xFF (code_point then holds the raw byte), with out_valid /
// out_ready.
// A multi-byte sequence gives one result when its last byte arrives; the
// earlier bytes give none. Bytes in continuation position are not checked.
// Throughput is one byte per cycle while the queue has room. A byte that
// completes a result is written into the two-entry queue when it is accepted
// and moves into the output register once it is at the queue head and the
// output register is free or being drained.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ready drops once both queue entries are taken.
// Reset clears the open sequence, empties the queue and drops out_valid;
// in_ready is low while rst is high.
module utf8_stream_decoder_top
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point,
  output logic            bad_lead
);

  logic      q_full;
  logic      push;
  u8d_item_t push_item;
  logic      pop;
  logic      q_valid;
  u8d_item_t q_item;

  // Classifier on the input side.
  u8d_front u_front (
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  // Queue between classifier and sequence unit.
  u8d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Sequence unit with the output register.
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .bad_lead   (bad_lead)
  );

endmodule

FILE: sv/u8d_checker.sv
module u8d_checker
  import u8d_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic [7:0]      in_byte,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CP_W-1:0] code_point,
  input logic            bad_lead
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(code_point) && $stable(bad_lead))
    else $error("result payload changed while stalled");

  // A flagged result is a raw byte with its top bit set.
  a_bad_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_lead |-> (code_point[CP_W-1:8] == '0) && code_point[7])
    else $error("flagged result is not a raw high byte");

  // Reset takes no byte and leaves no result.
  a_reset_idle: assert property (@(posedge clk)
    rst |-> !in_ready ##1 !out_valid)
    else $error("block active during or after reset");

  // A waiting input request keeps its byte.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte))
    else $error("input request changed while waiting");

endmodule

bind utf8_stream_decoder_top u8d_checker u_checker (.*);
